### rtl/taacl_pkg.sv
// shared types and constants of the trusted address acl match unit
// no dependencies; every other rtl file but taacl_ram refers to it by scoped names
`default_nettype none

package taacl_pkg;

  localparam int unsigned MAX_ENTRIES_DEF = 16;

  localparam int unsigned ADDR_W   = 128;
  localparam int unsigned SLOT_W   = 4;
  localparam int unsigned PREFIX_W = 8;
  localparam int unsigned CFG_W    = 5;
  localparam int unsigned STATUS_W = 2;

  // command codes
  localparam logic CMD_LOAD   = 1'b0;
  localparam logic CMD_LOOKUP = 1'b1;

  // result status codes
  localparam logic [STATUS_W-1:0] STATUS_LOOKUP_DONE = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_STORED      = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_REJECTED    = 2'd2;

  // longest legal prefix per family
  localparam logic [PREFIX_W-1:0] V4_PREFIX_MAX = 8'd32;
  localparam logic [PREFIX_W-1:0] V6_PREFIX_MAX = 8'd128;

  // upper half of an ipv4-mapped ipv6 low word
  localparam logic [31:0] V4_MAPPED_TAG = 32'h0000_FFFF;

  typedef struct packed {
    logic                command;
    logic [SLOT_W-1:0]   slot;
    logic [63:0]         address_upper;
    logic [63:0]         address_lower;
    logic                is_ipv6;
    logic                is_range;
    logic [PREFIX_W-1:0] prefix_bits;
  } item_t;

  typedef struct packed {
    logic                matched;
    logic [STATUS_W-1:0] status;
  } result_t;

  // one table slot: family, netmask, masked network
  typedef struct packed {
    logic              is_v6;
    logic [ADDR_W-1:0] netmask;
    logic [ADDR_W-1:0] network;
  } entry_t;

  // controller to datapath
  typedef struct packed {
    logic accept;
    logic rd_en;
    logic out_load;
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic is_lookup;
    logic count_zero;
    logic last_idx;
  } dp_status_t;

endpackage

`default_nettype wire

### rtl/taacl_in_if.sv
// input item channel: valid/ready handshake with the item fields
// depends on taacl_pkg for field widths
`default_nettype none

interface taacl_in_if;
  logic                                 valid;
  logic                                 ready;
  logic                                 command;
  logic [taacl_pkg::SLOT_W-1:0]         slot;
  logic [63:0]                          address_upper;
  logic [63:0]                          address_lower;
  logic                                 is_ipv6;
  logic                                 is_range;
  logic [taacl_pkg::PREFIX_W-1:0]       prefix_bits;

  modport source (
    output valid, command, slot, address_upper, address_lower, is_ipv6, is_range,
           prefix_bits,
    input  ready
  );

  modport sink (
    input  valid, command, slot, address_upper, address_lower, is_ipv6, is_range,
           prefix_bits,
    output ready
  );
endinterface

`default_nettype wire

### rtl/taacl_out_if.sv
// result item channel: valid/ready handshake with matched and status
// depends on taacl_pkg for field widths
`default_nettype none

interface taacl_out_if;
  logic                           valid;
  logic                           ready;
  logic                           matched;
  logic [taacl_pkg::STATUS_W-1:0] status;

  modport source (
    output valid, matched, status,
    input  ready
  );

  modport sink (
    input  valid, matched, status,
    output ready
  );
endinterface

`default_nettype wire

### rtl/taacl_ram.sv
// generic single write port, single read port ram with registered read
// no dependencies
`default_nettype none

module taacl_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                                    clk_i,
  input  wire logic                                    we_i,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]                        wdata_i,
  input  wire logic                                    re_i,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output      logic [WIDTH-1:0]                        rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

### rtl/taacl_dp.sv
// datapath: config register, entry builder, table ram, slot compare, result register
// depends on taacl_pkg and taacl_ram
`default_nettype none

module taacl_dp #(
  parameter int unsigned MAX_ENTRIES = taacl_pkg::MAX_ENTRIES_DEF,
  localparam int unsigned IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1,
  localparam int unsigned CNT_W = $clog2(MAX_ENTRIES + 1)
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        cfg_we_i,
  input  wire logic [taacl_pkg::CFG_W-1:0] cfg_wdata_i,
  input  wire taacl_pkg::item_t            item_i,
  input  wire taacl_pkg::ctrl_cmd_t        cmd_i,
  input  wire logic [IDX_W-1:0]            rd_idx_i,
  output      taacl_pkg::dp_status_t       status_o,
  output      taacl_pkg::result_t          result_o
);

  logic [taacl_pkg::CFG_W-1:0]    active_q;
  logic [CNT_W-1:0]               count;

  logic [taacl_pkg::ADDR_W-1:0]   ld_addr;
  logic [taacl_pkg::ADDR_W-1:0]   ld_mask;
  logic [31:0]                    v4_mask;
  logic [taacl_pkg::PREFIX_W-1:0] prefix_lim;
  logic                           load_ok;
  logic                           wr_en;
  taacl_pkg::entry_t              wr_entry;
  taacl_pkg::entry_t              rd_entry;

  logic                           mapped;
  logic                           lk_v6;
  logic [taacl_pkg::ADDR_W-1:0]   lk_addr;

  logic [taacl_pkg::ADDR_W-1:0]   addr_q;
  logic                           v6_q;
  logic                           cmp_valid_q;
  logic                           hit_q;
  logic                           hit_d;
  logic [taacl_pkg::STATUS_W-1:0] status_q;
  logic [taacl_pkg::STATUS_W-1:0] status_d;
  taacl_pkg::result_t             res_q;
  logic                           slot_hit;

  // clamp the active count to the table depth
  assign count = (32'(active_q) > 32'(MAX_ENTRIES)) ? CNT_W'(MAX_ENTRIES) : CNT_W'(active_q);

  // load side: netmask from prefix, network stored pre-masked
  always_comb begin
    prefix_lim = item_i.is_ipv6 ? taacl_pkg::V6_PREFIX_MAX : taacl_pkg::V4_PREFIX_MAX;
    load_ok    = (32'(item_i.slot) < 32'(MAX_ENTRIES))
                 && !(item_i.is_range && (item_i.prefix_bits > prefix_lim));
    v4_mask    = item_i.is_range ? ~({32{1'b1}} >> item_i.prefix_bits) : {32{1'b1}};
    if (item_i.is_ipv6) begin
      ld_addr = {item_i.address_upper, item_i.address_lower};
      ld_mask = item_i.is_range ? ~({taacl_pkg::ADDR_W{1'b1}} >> item_i.prefix_bits)
                                : {taacl_pkg::ADDR_W{1'b1}};
    end else begin
      ld_addr = {96'd0, item_i.address_lower[31:0]};
      ld_mask = {96'd0, v4_mask};
    end
    wr_entry.is_v6   = item_i.is_ipv6;
    wr_entry.netmask = ld_mask;
    wr_entry.network = ld_addr & ld_mask;
  end

  assign wr_en = cmd_i.accept && (item_i.command == taacl_pkg::CMD_LOAD) && load_ok;

  // lookup side: ipv4-mapped ipv6 folds to ipv4
  always_comb begin
    mapped  = item_i.is_ipv6 && (item_i.address_upper == 64'd0)
              && (item_i.address_lower[63:32] == taacl_pkg::V4_MAPPED_TAG);
    lk_v6   = item_i.is_ipv6 && !mapped;
    lk_addr = lk_v6 ? {item_i.address_upper, item_i.address_lower}
                    : {96'd0, item_i.address_lower[31:0]};
  end

  taacl_ram #(
    .WIDTH ($bits(taacl_pkg::entry_t)),
    .DEPTH (MAX_ENTRIES)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (IDX_W'(item_i.slot)),
    .wdata_i (wr_entry),
    .re_i    (cmd_i.rd_en),
    .raddr_i (rd_idx_i),
    .rdata_o (rd_entry)
  );

  assign slot_hit = (rd_entry.is_v6 == v6_q) && ((addr_q & rd_entry.netmask) == rd_entry.network);

  always_comb begin
    hit_d    = hit_q;
    status_d = status_q;
    if (cmd_i.accept) begin
      hit_d = 1'b0;
      if (item_i.command == taacl_pkg::CMD_LOOKUP) begin
        status_d = taacl_pkg::STATUS_LOOKUP_DONE;
      end else if (load_ok) begin
        status_d = taacl_pkg::STATUS_STORED;
      end else begin
        status_d = taacl_pkg::STATUS_REJECTED;
      end
    end else if (cmp_valid_q) begin
      hit_d = hit_q | slot_hit;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q    <= '0;
      cmp_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        active_q <= cfg_wdata_i;
      end
      cmp_valid_q <= cmd_i.rd_en;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      addr_q <= lk_addr;
      v6_q   <= lk_v6;
    end
    hit_q    <= hit_d;
    status_q <= status_d;
    if (cmd_i.out_load) begin
      res_q.matched <= hit_q;
      res_q.status  <= status_q;
    end
  end

  assign status_o.is_lookup  = (item_i.command == taacl_pkg::CMD_LOOKUP);
  assign status_o.count_zero = (count == '0);
  assign status_o.last_idx   = (rd_idx_i == IDX_W'(count - CNT_W'(1)));
  assign result_o            = res_q;

endmodule

`default_nettype wire

### rtl/taacl_ctrl.sv
// controller: accepts items, sequences the slot scan, owns the result valid
// depends on taacl_pkg
`default_nettype none

module taacl_ctrl #(
  parameter int unsigned MAX_ENTRIES = taacl_pkg::MAX_ENTRIES_DEF,
  localparam int unsigned IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output      logic                  in_ready_o,
  output      logic                  out_valid_o,
  input  wire logic                  out_ready_i,
  input  wire taacl_pkg::dp_status_t status_i,
  output      taacl_pkg::ctrl_cmd_t  cmd_o,
  output      logic [IDX_W-1:0]      rd_idx_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_DONE
  } state_e;

  state_e           state_q, state_d;
  logic [IDX_W-1:0] idx_q, idx_d;
  logic             out_valid_q, out_valid_d;
  logic             accept;

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    state_d        = state_q;
    idx_d          = idx_q;
    out_valid_d    = out_valid_q;
    cmd_o.accept   = accept;
    cmd_o.rd_en    = 1'b0;
    cmd_o.out_load = 1'b0;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          idx_d = '0;
          if (status_i.is_lookup && !status_i.count_zero) begin
            state_d = ST_SCAN;
          end else begin
            state_d = ST_DONE;
          end
        end
      end
      ST_SCAN: begin
        cmd_o.rd_en = 1'b1;
        if (status_i.last_idx) begin
          state_d = ST_DRAIN;
        end else begin
          idx_d = idx_q + IDX_W'(1);
        end
      end
      ST_DRAIN: begin
        state_d = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign rd_idx_o    = idx_q;
  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

### rtl/trusted_address_acl_match_unit.sv
// top level of the trusted address acl match unit
// depends on taacl_pkg, taacl_in_if, taacl_out_if, taacl_ctrl, taacl_dp, taacl_ram
`default_nettype none

// Trusted address table with CIDR prefix matching. A load item (command 0)
// writes one slot with an IPv4 or IPv6 exact address or subnet; the netmask
// is built from prefix_bits and the network is stored already masked. The
// result of a load has status 1 (stored) or 2 (rejected: slot beyond the
// table, or prefix above 32 for IPv4 / 128 for IPv6, slot left unchanged).
// A lookup item (command 1) folds an IPv4-mapped IPv6 address to IPv4, then
// compares it with slots 0 to active_entries-1, clamped to the depth, of
// the same family and returns matched with status 0. A load, or a lookup
// with a zero count, goes from idle to the done state, which loads the
// result register; a lookup walks the table one slot per cycle through the
// single read port of the table ram, then a drain state compares the last
// slot. One item is in work at a time; the next is accepted as soon as the
// result sits in the output register, even if the sink has not taken it
// yet. Slots come up undefined after reset: a lookup must not reach a slot
// that was never loaded. active_entries resets to zero and is written via
// cfg_we_i/cfg_wdata_i, by the user only while idle; it is not enforced.
module trusted_address_acl_match_unit #(
  parameter int unsigned MAX_ENTRIES = taacl_pkg::MAX_ENTRIES_DEF,
  localparam int unsigned IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        cfg_we_i,
  input  wire logic [taacl_pkg::CFG_W-1:0] cfg_wdata_i,
  taacl_in_if.sink                         in_i,
  taacl_out_if.source                      out_o
);

  taacl_pkg::item_t      item;
  taacl_pkg::ctrl_cmd_t  cmd;
  taacl_pkg::dp_status_t dp_status;
  taacl_pkg::result_t    result;
  logic [IDX_W-1:0]      rd_idx;
  logic                  in_ready;
  logic                  out_valid;

  // flatten the input channel payload for the datapath
  assign item.command       = in_i.command;
  assign item.slot          = in_i.slot;
  assign item.address_upper = in_i.address_upper;
  assign item.address_lower = in_i.address_lower;
  assign item.is_ipv6       = in_i.is_ipv6;
  assign item.is_range      = in_i.is_range;
  assign item.prefix_bits   = in_i.prefix_bits;

  // sequencer: accept, scan slots, hand off result
  taacl_ctrl #(
    .MAX_ENTRIES (MAX_ENTRIES)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_ready),
    .out_valid_o (out_valid),
    .out_ready_i (out_o.ready),
    .status_i    (dp_status),
    .cmd_o       (cmd),
    .rd_idx_o    (rd_idx)
  );

  // table, entry builder, compare and result register
  taacl_dp #(
    .MAX_ENTRIES (MAX_ENTRIES)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .item_i      (item),
    .cmd_i       (cmd),
    .rd_idx_i    (rd_idx),
    .status_o    (dp_status),
    .result_o    (result)
  );

  assign in_i.ready    = in_ready;
  assign out_o.valid   = out_valid;
  assign out_o.matched = result.matched;
  assign out_o.status  = result.status;

`ifndef NO_ASSERTIONS
  // an accepted item leaves the block not ready in the cycle after
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_ready) |=> !in_ready)
    else $error("item accepted back to back");

  // result register only reloads when it is free or being drained
  a_out_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.out_load |-> (!out_valid || out_o.ready))
    else $error("result overwritten before it was taken");

  // scan reads stay inside the table
  a_rd_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.rd_en |-> (32'(rd_idx) < 32'(MAX_ENTRIES)))
    else $error("slot read beyond table depth");

  // a lookup with no active slots never touches the table
  a_empty_no_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_ready && dp_status.is_lookup && dp_status.count_zero)
      |=> !cmd.rd_en)
    else $error("table read on empty lookup");
`endif

endmodule

`default_nettype wire

### dv/trusted_address_acl_match_unit_tb.sv
// testbench for trusted_address_acl_match_unit: directed table, then random loads and lookups
// depends on taacl_pkg, taacl_in_if, taacl_out_if and the rtl of the unit
module trusted_address_acl_match_unit_tb;

  localparam int unsigned SLOTS          = taacl_pkg::MAX_ENTRIES_DEF;
  localparam int unsigned RANDOM_ITEMS   = 800;
  // wait out the longest lookup; leave margin on top
  localparam int unsigned SETTLE_CYCLES  = 24;
  localparam int unsigned WATCHDOG_LIMIT = 2000;

  typedef logic [taacl_pkg::SLOT_W-1:0]           slot_t;
  typedef logic [taacl_pkg::PREFIX_W-1:0]         prefix_t;
  typedef logic [taacl_pkg::CFG_W-1:0]            count_t;
  typedef logic [$clog2(taacl_pkg::ADDR_W)-1:0]   bitidx_t;

  logic   clk_i;
  logic   rst_ni;
  logic   cfg_we_i;
  count_t cfg_wdata_i;

  taacl_in_if  in_if ();
  taacl_out_if out_if ();

  trusted_address_acl_match_unit #(
    .MAX_ENTRIES(SLOTS)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_i       (in_if),
    .out_o      (out_if)
  );

  // one row of the directed plan: either a count write or an item
  typedef struct {
    bit                 set_count;
    count_t             count;
    taacl_pkg::item_t   it;
    bit                 typed;
    taacl_pkg::result_t want;
  } plan_row_t;

  // shadow of the trusted table as the unit should hold it
  logic [taacl_pkg::ADDR_W-1:0] tbl_network   [SLOTS];
  logic [taacl_pkg::ADDR_W-1:0] tbl_netmask   [SLOTS];
  bit                           tbl_is_v6     [SLOTS];
  bit                           tbl_loaded    [SLOTS];
  count_t                       active_count;

  // verdicts owed by the unit, oldest first
  taacl_pkg::result_t pending_verdicts [$];
  plan_row_t          plan [$];

  int unsigned error_count;
  int unsigned stall_cycles;
  int unsigned burst_left;
  bit          valid_up;
  int unsigned n_stored, n_rejected, n_hits, n_misses, n_mapped, n_settings;

  // clock
  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  function automatic taacl_pkg::item_t make_item(logic cmd, slot_t slot, logic [63:0] hi,
                                                 logic [63:0] lo, logic v6, logic subnet,
                                                 prefix_t pfx);
    taacl_pkg::item_t it;
    it.command       = cmd;
    it.slot          = slot;
    it.address_upper = hi;
    it.address_lower = lo;
    it.is_ipv6       = v6;
    it.is_range      = subnet;
    it.prefix_bits   = pfx;
    return it;
  endfunction

  // ---------------------------------------------------------------------------
  // acl predictor: applies a load to the shadow table, or walks the active
  // slots for a lookup, and returns the verdict the unit owes for the item
  // ---------------------------------------------------------------------------
  function automatic taacl_pkg::result_t acl_predict(taacl_pkg::item_t it);
    taacl_pkg::result_t           r;
    logic [taacl_pkg::ADDR_W-1:0] addr;
    logic [taacl_pkg::ADDR_W-1:0] full;
    logic [taacl_pkg::ADDR_W-1:0] mask;
    bit                           v6;
    int unsigned                  span;
    int unsigned                  i;
    r.matched = 1'b0;
    v6 = it.is_ipv6;
    if (it.command == taacl_pkg::CMD_LOAD) begin
      // prefix beyond the family width leaves the slot as it was
      if (int'(it.slot) >= SLOTS ||
          (it.is_range && it.prefix_bits > (v6 ? taacl_pkg::V6_PREFIX_MAX
                                                : taacl_pkg::V4_PREFIX_MAX))) begin
        r.status = taacl_pkg::STATUS_REJECTED;
        return r;
      end
      // ipv4 lives in the low 32 bits, everything above is dropped
      full = v6 ? '1 : {{(taacl_pkg::ADDR_W-32){1'b0}}, 32'hFFFF_FFFF};
      // leading prefix_bits ones within the family width; exact is all ones
      mask = it.is_range ? (full & ~(full >> it.prefix_bits)) : full;
      addr = {it.address_upper, it.address_lower} & full;
      tbl_network[it.slot] = addr & mask;
      tbl_netmask[it.slot] = mask;
      tbl_is_v6[it.slot]   = v6;
      tbl_loaded[it.slot]  = 1'b1;
      r.status = taacl_pkg::STATUS_STORED;
      return r;
    end
    // ::ffff:a.b.c.d is looked up as plain ipv4
    if (v6 && it.address_upper == '0 &&
        it.address_lower[63:32] == taacl_pkg::V4_MAPPED_TAG) v6 = 1'b0;
    addr = v6 ? {it.address_upper, it.address_lower}
              : {{(taacl_pkg::ADDR_W-32){1'b0}}, it.address_lower[31:0]};
    span = (active_count > SLOTS) ? SLOTS : active_count;
    for (i = 0; i < span; i++) begin
      if (tbl_is_v6[slot_t'(i)] == v6 &&
          (addr & tbl_netmask[slot_t'(i)]) == tbl_network[slot_t'(i)]) r.matched = 1'b1;
    end
    r.status = taacl_pkg::STATUS_LOOKUP_DONE;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic void add_item(taacl_pkg::item_t it);
    plan_row_t row;
    row.set_count = 1'b0;
    row.count     = '0;
    row.it        = it;
    row.typed     = 1'b0;
    row.want      = '0;
    plan.push_back(row);
  endfunction

  function automatic void add_typed(taacl_pkg::item_t it, logic m,
                                    logic [taacl_pkg::STATUS_W-1:0] st);
    plan_row_t row;
    row.set_count    = 1'b0;
    row.count        = '0;
    row.it           = it;
    row.typed        = 1'b1;
    row.want.matched = m;
    row.want.status  = st;
    plan.push_back(row);
  endfunction

  function automatic void add_count(count_t v);
    plan_row_t row;
    row.set_count = 1'b1;
    row.count     = v;
    row.it        = '0;
    row.typed     = 1'b0;
    row.want      = '0;
    plan.push_back(row);
  endfunction

  // a load into the given slot; an illegal one carries a prefix past the family width
  function automatic taacl_pkg::item_t random_load(slot_t slot, bit legal);
    logic        v6;
    logic        subnet;
    int unsigned lim;
    int unsigned pfx;
    v6     = 1'($urandom_range(0, 1));
    subnet = !legal || ($urandom_range(0, 9) < 7);
    lim    = v6 ? 128 : 32;
    if (!subnet) pfx = $urandom_range(0, 255);
    else if (legal) pfx = $urandom_range(0, lim);
    else pfx = $urandom_range(lim + 1, 255);
    return make_item(taacl_pkg::CMD_LOAD, slot, {$urandom, $urandom}, {$urandom, $urandom},
                     v6, subnet, pfx[taacl_pkg::PREFIX_W-1:0]);
  endfunction

  // mostly lookups aimed at a live entry, plus loads and plain noise
  function automatic taacl_pkg::item_t random_item();
    taacl_pkg::item_t             it;
    logic [taacl_pkg::ADDR_W-1:0] addr;
    int unsigned                  pick;
    int unsigned                  span;
    int unsigned                  i;
    int unsigned                  b;
    logic [63:0]                  hi;
    logic [63:0]                  lo;
    logic                         v6;
    pick = $urandom_range(0, 99);
    if (pick < 30) begin
      return random_load(slot_t'($urandom_range(0, SLOTS - 1)), $urandom_range(0, 7) != 0);
    end
    hi = {$urandom, $urandom};
    lo = {$urandom, $urandom};
    v6 = 1'($urandom_range(0, 1));
    if (pick < 85) begin
      span = (active_count > SLOTS) ? SLOTS : active_count;
      i = (span > 0) ? $urandom_range(0, span - 1) : $urandom_range(0, SLOTS - 1);
      if (!tbl_loaded[slot_t'(i)]) i = 0;
      // keep the network bits, randomize the host bits
      addr = tbl_network[slot_t'(i)] |
             ({$urandom, $urandom, $urandom, $urandom} & ~tbl_netmask[slot_t'(i)]);
      // near miss: flip one network bit
      if ($urandom_range(0, 3) == 0 && tbl_netmask[slot_t'(i)] != '0) begin
        b = $urandom_range(0, taacl_pkg::ADDR_W - 1);
        while (!tbl_netmask[slot_t'(i)][bitidx_t'(b)]) b = $urandom_range(0, taacl_pkg::ADDR_W - 1);
        addr[bitidx_t'(b)] = ~addr[bitidx_t'(b)];
      end
      if (tbl_is_v6[slot_t'(i)]) begin
        hi = addr[127:64];
        lo = addr[63:0];
        v6 = 1'b1;
      end else if ($urandom_range(0, 2) == 0) begin
        hi = '0;
        lo = {taacl_pkg::V4_MAPPED_TAG, addr[31:0]};
        v6 = 1'b1;
      end else begin
        lo = {lo[63:32], addr[31:0]};
        v6 = 1'b0;
      end
    end else if ($urandom_range(0, 3) == 0) begin
      // random address in mapped form
      hi = '0;
      lo[63:32] = taacl_pkg::V4_MAPPED_TAG;
      v6 = 1'b1;
    end
    it = make_item(taacl_pkg::CMD_LOOKUP, slot_t'($urandom_range(0, SLOTS - 1)), hi, lo, v6,
                   1'($urandom_range(0, 1)), prefix_t'($urandom_range(0, 255)));
    return it;
  endfunction

  // lower valid only if it is up, so no step sees it both raised and lowered
  task automatic hold_input();
    if (valid_up) begin
      in_if.valid <= 1'b0;
      valid_up = 1'b0;
    end
  endtask

  // stop sending and wait until every owed verdict has come back
  task automatic drain();
    hold_input();
    while (pending_verdicts.size() != 0) @(posedge clk_i);
  endtask

  // offer one item, wait for the handshake, record the verdict it owes
  task automatic send_item(taacl_pkg::item_t it, bit typed, taacl_pkg::result_t want);
    taacl_pkg::result_t r;
    in_if.valid         <= 1'b1;
    in_if.command       <= it.command;
    in_if.slot          <= it.slot;
    in_if.address_upper <= it.address_upper;
    in_if.address_lower <= it.address_lower;
    in_if.is_ipv6       <= it.is_ipv6;
    in_if.is_range      <= it.is_range;
    in_if.prefix_bits   <= it.prefix_bits;
    valid_up = 1'b1;
    do @(posedge clk_i); while (in_if.ready !== 1'b1);
    r = acl_predict(it);
    if (typed) r = want;
    pending_verdicts.push_back(r);
    if (it.command == taacl_pkg::CMD_LOOKUP && it.is_ipv6 && it.address_upper == '0 &&
        it.address_lower[63:32] == taacl_pkg::V4_MAPPED_TAG) n_mapped++;
    // bursts of random length, random gaps in between
    if (burst_left == 0) begin
      hold_input();
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 80) : $urandom_range(0, 8);
    end else begin
      burst_left--;
    end
  endtask

  // the count register is written only with the unit idle
  task automatic set_count(count_t v);
    drain();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    active_count = v;
    n_settings++;
  endtask

  // ---------------------------------------------------------------------------
  // result side: stall pattern of its own, reshuffled at the start of each
  // window; a quarter of the windows never stall, and no pattern is all
  // stall
  initial begin
    logic [7:0]  pat;
    int unsigned tick;
    out_if.ready <= 1'b0;
    pat  = 8'hFF;
    tick = 0;
    forever begin
      @(posedge clk_i);
      if (tick % 64 == 0) pat = ($urandom_range(0, 3) == 0) ? 8'hFF : 8'($urandom_range(1, 255));
      out_if.ready <= pat[3'(tick)];
      tick++;
    end
  end

  // check every accepted verdict against the oldest one owed
  always @(posedge clk_i) begin
    taacl_pkg::result_t want;
    if (rst_ni && out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
      if (pending_verdicts.size() == 0) begin
        error_count++;
        $display("%0t: unexpected result, expected none, actual matched %0b status %0d",
                 $time, out_if.matched, out_if.status);
      end else begin
        want = pending_verdicts.pop_front();
        if (out_if.matched !== want.matched) begin
          error_count++;
          $display("%0t: matched mismatch, expected %0b, actual %0b",
                   $time, want.matched, out_if.matched);
        end
        if (out_if.status !== want.status) begin
          error_count++;
          $display("%0t: status mismatch, expected %0d, actual %0d",
                   $time, want.status, out_if.status);
        end
      end
      if (out_if.status == taacl_pkg::STATUS_STORED) n_stored++;
      else if (out_if.status == taacl_pkg::STATUS_REJECTED) n_rejected++;
      else if (out_if.matched) n_hits++;
      else n_misses++;
    end
  end

  // watchdog: cycles in a row with no handshake on either side
  always @(posedge clk_i) begin
    if (!rst_ni || (in_if.valid === 1'b1 && in_if.ready === 1'b1) ||
        (out_if.valid === 1'b1 && out_if.ready === 1'b1)) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
      if (stall_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: no handshake for %0d cycles", $time, stall_cycles);
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin
    int unsigned        sent;
    int unsigned        phase;
    int unsigned        len;
    int unsigned        s;
    count_t             forced_counts [6] = '{5'd31, 5'd16, 5'd17, 5'd0, 5'd1, 5'd15};
    taacl_pkg::result_t none;
    none = '0;
    rst_ni = 1'b0;
    cfg_we_i            <= 1'b0;
    cfg_wdata_i         <= '0;
    in_if.valid         <= 1'b0;
    in_if.command       <= taacl_pkg::CMD_LOAD;
    in_if.slot          <= '0;
    in_if.address_upper <= '0;
    in_if.address_lower <= '0;
    in_if.is_ipv6       <= 1'b0;
    in_if.is_range      <= 1'b0;
    in_if.prefix_bits   <= '0;
    valid_up     = 1'b0;
    burst_left   = 0;
    active_count = '0;
    error_count  = 0;
    stall_cycles = 0;

    // directed plan; typed verdicts where they are obvious
    // count is zero after reset, so nothing can match
    add_typed(make_item(taacl_pkg::CMD_LOOKUP, 4'hF, '0, 64'h0000_0000_0A01_0203, 1'b0, 1'b0,
                        8'd0), 1'b0, taacl_pkg::STATUS_LOOKUP_DONE);
    // exact ipv4 with junk above bit 31 and a prefix that must be ignored
    add_typed(make_item(taacl_pkg::CMD_LOAD, 4'd0, '1, 64'hFFFF_FFFF_0A01_0203, 1'b0, 1'b0,
                        8'hFF), 1'b0, taacl_pkg::STATUS_STORED);
    add_typed(make_item(taacl_pkg::CMD_LOAD, 4'd1, '0, 64'h0000_0000_C0A8_1234, 1'b0, 1'b1,
                        8'd16), 1'b0, taacl_pkg::STATUS_STORED);
    add_typed(make_item(taacl_pkg::CMD_LOAD, 4'd2, '0, 64'h0000_0000_FFFF_FFFF, 1'b0, 1'b1,
                        8'd32), 1'b0, taacl_pkg::STATUS_STORED);
    // ipv4 prefix past 32 is refused, slot untouched
    add_typed(make_item(taacl_pkg::CMD_LOAD, 4'd3, '0, 64'h0000_0000_0102_0304, 1'b0, 1'b1,
                        8'd33), 1'b0, taacl_pkg::STATUS_REJECTED);
    add_typed(make_item(taacl_pkg::CMD_LOAD, 4'd3, '0, 64'h0000_0000_0102_0304, 1'b0, 1'b1,
                        8'hFF), 1'b0, taacl_pkg::STATUS_REJECTED);
    add_typed(make_item(taacl_pkg::CMD_LOAD, 4'd3, '1, '1, 1'b1, 1'b0, 8'd0), 1'b0,
              taacl_pkg::STATUS_STORED);
    add_typed(make_item(taacl_pkg::CMD_LOAD, 4'd4, 64'h2001_0DB8_0000_0001, 64'h42, 1'b1, 1'b1,
                        8'd128), 1'b0, taacl_pkg::STATUS_STORED);
    add_typed(make_item(taacl_pkg::CMD_LOAD, 4'd5, 64'hFE80_0000_0000_0000, 64'h1234, 1'b1,
                        1'b1, 8'd64), 1'b0, taacl_pkg::STATUS_STORED);
    // ipv6 prefix past 128 is refused
    add_typed(make_item(taacl_pkg::CMD_LOAD, 4'd6, '1, '1, 1'b1, 1'b1, 8'd129), 1'b0,
              taacl_pkg::STATUS_REJECTED);
    add_typed(make_item(taacl_pkg::CMD_LOAD, 4'd6, '1, '1, 1'b1, 1'b1, 8'hFF), 1'b0,
              taacl_pkg::STATUS_REJECTED);
    add_typed(make_item(taacl_pkg::CMD_LOAD, 4'd6, 64'h8000_0000_0000_0001, '1, 1'b1, 1'b1,
                        8'd1), 1'b0, taacl_pkg::STATUS_STORED);
    add_typed(make_item(taacl_pkg::CMD_LOAD, 4'd7, '0, '0, 1'b1, 1'b0, 8'd0), 1'b0,
              taacl_pkg::STATUS_STORED);
    add_typed(make_item(taacl_pkg::CMD_LOAD, 4'd8, '0, 64'h0000_0000_0A00_0000, 1'b0, 1'b1,
                        8'd8), 1'b0, taacl_pkg::STATUS_STORED);
    // slots 0 to 8 are live now
    add_count(5'd9);
    add_item(make_item(taacl_pkg::CMD_LOOKUP, 4'h0, '1, 64'hDEAD_BEEF_0A01_0203, 1'b0, 1'b1,
                       8'hFF));
    add_item(make_item(taacl_pkg::CMD_LOOKUP, 4'h5, '0, 64'h0000_FFFF_C0A8_4D01, 1'b1, 1'b0,
                       8'd0));
    add_item(make_item(taacl_pkg::CMD_LOOKUP, 4'hA, '0, 64'h0000_0000_C0A9_0000, 1'b0, 1'b0,
                       8'd0));
    add_item(make_item(taacl_pkg::CMD_LOOKUP, 4'h3, '1, '1, 1'b1, 1'b0, 8'd0));
    add_item(make_item(taacl_pkg::CMD_LOOKUP, 4'hF, '0, '0, 1'b1, 1'b0, 8'd0));
    // one bit off the mapped tag stays ipv6
    add_item(make_item(taacl_pkg::CMD_LOOKUP, 4'h1, '0, 64'h0001_FFFF_0A01_0203, 1'b1, 1'b0,
                       8'd0));
    add_item(make_item(taacl_pkg::CMD_LOOKUP, 4'h2, 64'h2001_0DB8_0000_0001, 64'h42, 1'b1,
                       1'b0, 8'd0));
    add_count(5'd0);
    add_typed(make_item(taacl_pkg::CMD_LOOKUP, 4'h0, '1, '1, 1'b1, 1'b0, 8'd0), 1'b0,
              taacl_pkg::STATUS_LOOKUP_DONE);
    // catch-all subnets at the top of the table: slot 14 needs a count of 15 and up, slot 15 the full count
    add_typed(make_item(taacl_pkg::CMD_LOAD, 4'd15, '0, 64'h0000_0000_1234_5678, 1'b0, 1'b1,
                        8'd0), 1'b0, taacl_pkg::STATUS_STORED);
    add_typed(make_item(taacl_pkg::CMD_LOAD, 4'd14, '1, '1, 1'b1, 1'b1, 8'd0), 1'b0,
              taacl_pkg::STATUS_STORED);

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (plan[k]) begin
      if (plan[k].set_count) set_count(plan[k].count);
      else send_item(plan[k].it, plan[k].typed, plan[k].want);
    end

    // fill the slots still empty, with random traffic in between; the count
    // stays inside the directed slots meanwhile
    set_count(count_t'($urandom_range(1, 9)));
    sent = 0;
    for (s = 0; s < SLOTS; s++) begin
      if (!tbl_loaded[slot_t'(s)]) begin
        send_item(random_load(slot_t'(s), 1'b1), 1'b0, none);
        send_item(random_item(), 1'b0, none);
        send_item(random_item(), 1'b0, none);
        sent += 3;
      end
    end

    // every slot holds an entry now, so any count is safe; the first phases
    // cover the clamp, the full table and an empty one
    phase = 0;
    while (sent < RANDOM_ITEMS) begin
      set_count((phase < 6) ? forced_counts[3'(phase)] : count_t'($urandom_range(0, 31)));
      len = $urandom_range(20, 90);
      repeat (len) begin
        send_item(random_item(), 1'b0, none);
        sent++;
        // now and then let everything drain mid-phase
        if ($urandom_range(0, 60) == 0) drain();
      end
      phase++;
    end

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    $display("lookups: %0d hits, %0d misses, %0d sent in mapped form", n_hits, n_misses,
             n_mapped);
    $display("loads: %0d stored, %0d refused; %0d count settings from 0 to 31", n_stored,
             n_rejected, n_settings);
    if (error_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
